// ===== src/text_console_character_writer_macros.svh =====
// Assertion macros for the text console character writer.
// Used by the top level only; expects signals named clk and rst_n in scope.
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define TCCW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tccw same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define TCCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tccw next-cycle check failed");

`endif

// ===== src/tccw_pkg.sv =====
// Shared constants, codes and types of the text console character writer.
// No dependencies; every other file but the macros header imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS  = 80;
  localparam int DEF_ROWS     = 25;
  localparam int DEF_TAB_STOP = 8;

  // Field widths.
  localparam int OP_W       = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int CELL_W     = 16;
  localparam int ATTR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERIAL_MIRROR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTRIBUTE = 2'd2;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  // Depth of the command queue between front and back.
  localparam int FIFO_DEPTH = 2;

  // Command kinds decided by the front.
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_NOP     = 3'd0;
  localparam kind_t KIND_CHAR    = 3'd1;
  localparam kind_t KIND_TAB     = 3'd2;
  localparam kind_t KIND_NEWLINE = 3'd3;
  localparam kind_t KIND_CLEAR   = 3'd4;
  localparam kind_t KIND_READ    = 3'd5;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } cmd_t;

  typedef struct packed {
    logic              enabled;
    logic              serial_mirror;
    logic [ATTR_W-1:0] text_attribute;
  } cfg_t;

  typedef struct packed {
    logic init_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== src/tccw_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
// Depends on tccw_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tccw_in_if;
  import tccw_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output operation, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input operation, input char_code, input cell_index,
                output ready);
endinterface

interface tccw_out_if;
  import tccw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] serial_byte;
  logic              serial_valid;
  logic [IDX_W-1:0]  cursor_position;
  logic [CELL_W-1:0] cell_value;
  logic              last;

  modport source (output valid, output serial_byte, output serial_valid,
                  output cursor_position, output cell_value, output last, input ready);
  modport sink (input valid, input serial_byte, input serial_valid,
                input cursor_position, input cell_value, input last, output ready);
endinterface

`default_nettype wire

// ===== src/tccw_front.sv =====
// Front end: accepts input items and turns them into queued commands.
// Depends on tccw_pkg and tccw_in_if.
`timescale 1ns / 1ps
`default_nettype none

module tccw_front (
  tccw_in_if.sink           in_chan,
  input  tccw_pkg::cfg_t    cfg_i,
  input  tccw_pkg::status_t status_i,
  input  logic              fifo_full_i,
  output logic              push_o,
  output tccw_pkg::cmd_t    cmd_o
);
  import tccw_pkg::*;

  // Take an item whenever the queue has room and the power-up clear is done.
  assign in_chan.ready = !fifo_full_i && !status_i.init_busy;

  // A disabled block drops the item without a result.
  assign push_o = in_chan.valid && in_chan.ready && cfg_i.enabled;

  // Sort the item into the kind of work the back end has to do.
  always_comb begin
    cmd_o.char_code  = in_chan.char_code;
    cmd_o.cell_index = in_chan.cell_index;
    case (in_chan.operation)
      OP_CLEAR: cmd_o.kind = KIND_CLEAR;
      OP_READ:  cmd_o.kind = KIND_READ;
      OP_PUT: begin
        case (in_chan.char_code)
          CHAR_NUL: cmd_o.kind = KIND_NOP;
          CHAR_LF:  cmd_o.kind = KIND_NEWLINE;
          CHAR_TAB: cmd_o.kind = KIND_TAB;
          default:  cmd_o.kind = KIND_CHAR;
        endcase
      end
      default: cmd_o.kind = KIND_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tccw_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on tccw_pkg for the command type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module tccw_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  tccw_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tccw_pkg::cmd_t head_o
);
  import tccw_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  cmd_t          slot_r [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full_o  = (count_r == CW'(FIFO_DEPTH));
  assign empty_o = (count_r == '0);
  assign head_o  = slot_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage slots carry payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/tccw_back.sv =====
// Back end: screen memory, cursor, scroll and clear sequencer, result register.
// Depends on tccw_pkg and tccw_out_if.
`timescale 1ns / 1ps
`default_nettype none

module tccw_back #(
  parameter int COLUMNS  = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS     = tccw_pkg::DEF_ROWS,
  parameter int TAB_STOP = tccw_pkg::DEF_TAB_STOP
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tccw_pkg::cfg_t    cfg_i,
  input  logic              fifo_empty_i,
  input  tccw_pkg::cmd_t    head_i,
  output logic              pop_o,
  output tccw_pkg::status_t status_o,
  tccw_out_if.source        out_chan
);
  import tccw_pkg::*;

  localparam int CELL_COUNT     = COLUMNS * ROWS;
  localparam int COPY_COUNT     = CELL_COUNT - COLUMNS;
  localparam int AW             = $clog2(CELL_COUNT);
  localparam int PW             = $clog2(CELL_COUNT + 1);
  localparam int CLW            = $clog2(COLUMNS);
  localparam int TW             = $clog2(TAB_STOP + 1);
  localparam int IXW            = (AW > IDX_W) ? AW : IDX_W;
  localparam int COL_MOD        = COLUMNS % TAB_STOP;
  localparam int LAST_PHASE     = COPY_COUNT % TAB_STOP;

  localparam logic [2:0] S_CLEAR     = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_EXEC      = 3'd2;
  localparam logic [2:0] S_READ_WAIT = 3'd3;
  localparam logic [2:0] S_SCROLL    = 3'd4;
  localparam logic [2:0] S_RESP      = 3'd5;
  localparam logic [2:0] S_RESP2     = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic              clr_item_r, clr_item_nxt;
  logic [PW-1:0]     ptr_r, ptr_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [AW-1:0]     cursor_r, cursor_nxt;
  logic [CLW-1:0]    col_r, col_nxt;
  logic [TW-1:0]     phase_r, phase_nxt;
  logic [TW-1:0]     row_phase_r, row_phase_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_sval_r, out_sval_nxt;
  logic [IDX_W-1:0]  out_cursor_r, out_cursor_nxt;
  logic [CELL_W-1:0] out_cell_r, out_cell_nxt;
  logic              out_last_r, out_last_nxt;

  // Screen memory with one write and one registered read port.
  logic [CELL_W-1:0] screen_mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_r;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  // Cursor advance helpers.
  logic              at_end, col_wrap, tab_done, out_free, mirror_it;
  logic [AW-1:0]     cur_inc, cur_nl;
  logic [CLW-1:0]    col_inc;
  logic [TW-1:0]     phase_inc, rp_adv;
  logic [TW:0]       rp_sum, rp_sub;
  logic [CLW:0]      nl_step;
  logic [IXW-1:0]    idx_ext, cur_ext;
  logic              idx_in_range;
  logic [PW-1:0]     wr_ptr;

  assign at_end    = (cursor_r == AW'(CELL_COUNT - 1));
  assign cur_inc   = cursor_r + 1'b1;
  assign col_wrap  = (col_r == CLW'(COLUMNS - 1));
  assign col_inc   = col_wrap ? '0 : col_r + 1'b1;
  assign tab_done  = (phase_r == TW'(TAB_STOP - 1));
  assign phase_inc = tab_done ? '0 : phase_r + 1'b1;
  // Phase of the next row start: one add and one conditional subtract.
  assign rp_sum    = {1'b0, row_phase_r} + (TW + 1)'(COL_MOD);
  assign rp_sub    = rp_sum - (TW + 1)'(TAB_STOP);
  assign rp_adv    = (rp_sum >= (TW + 1)'(TAB_STOP)) ? rp_sub[TW-1:0] : rp_sum[TW-1:0];
  assign nl_step   = (CLW + 1)'(COLUMNS) - {1'b0, col_r};
  assign cur_nl    = cursor_r + AW'(nl_step);

  assign idx_ext      = IXW'(cmd_r.cell_index);
  assign idx_in_range = (32'(cmd_r.cell_index) < CELL_COUNT);
  assign cur_ext      = IXW'(cursor_r);
  assign wr_ptr       = ptr_r - 1'b1;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign mirror_it = cfg_i.serial_mirror &&
                     (cmd_r.kind inside {KIND_CHAR, KIND_TAB, KIND_NEWLINE});

  assign status_o.init_busy = (state_r == S_CLEAR) && !clr_item_r;

  assign out_chan.valid           = out_valid_r;
  assign out_chan.serial_byte     = out_byte_r;
  assign out_chan.serial_valid    = out_sval_r;
  assign out_chan.cursor_position = out_cursor_r;
  assign out_chan.cell_value      = out_cell_r;
  assign out_chan.last            = out_last_r;

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    clr_item_nxt   = clr_item_r;
    ptr_nxt        = ptr_r;
    cmd_nxt        = cmd_r;
    cursor_nxt     = cursor_r;
    col_nxt        = col_r;
    phase_nxt      = phase_r;
    row_phase_nxt  = row_phase_r;
    rd_ok_nxt      = rd_ok_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_byte_nxt   = out_byte_r;
    out_sval_nxt   = out_sval_r;
    out_cursor_nxt = out_cursor_r;
    out_cell_nxt   = out_cell_r;
    out_last_nxt   = out_last_r;
    pop_o          = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = cursor_r;
    mem_raddr      = idx_ext[AW-1:0];
    mem_wdata      = {cfg_i.text_attribute, cmd_r.char_code};

    case (state_r)
      // Zero every cell, one a cycle.
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        mem_wdata = '0;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == PW'(CELL_COUNT - 1)) begin
          state_nxt    = clr_item_r ? S_RESP : S_IDLE;
          clr_item_nxt = 1'b0;
        end
      end

      S_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o     = 1'b1;
          cmd_nxt   = head_i;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (cmd_r.kind)
          KIND_READ: begin
            mem_re    = idx_in_range;
            rd_ok_nxt = idx_in_range;
            state_nxt = S_READ_WAIT;
          end
          KIND_CLEAR: begin
            ptr_nxt       = '0;
            clr_item_nxt  = 1'b1;
            cursor_nxt    = '0;
            col_nxt       = '0;
            phase_nxt     = '0;
            row_phase_nxt = '0;
            state_nxt     = S_CLEAR;
          end
          KIND_CHAR, KIND_TAB: begin
            mem_we = 1'b1;
            if (cmd_r.kind == KIND_TAB) begin
              mem_wdata = {cfg_i.text_attribute, CHAR_SPACE};
            end
            if (at_end) begin
              ptr_nxt   = '0;
              state_nxt = S_SCROLL;
            end else begin
              cursor_nxt = cur_inc;
              col_nxt    = col_inc;
              phase_nxt  = phase_inc;
              if (col_wrap) begin
                row_phase_nxt = rp_adv;
              end
              // A tab keeps writing spaces until the next stop.
              if (cmd_r.kind == KIND_CHAR || tab_done) begin
                state_nxt = S_RESP;
              end
            end
          end
          KIND_NEWLINE: begin
            if (cursor_r >= AW'(COPY_COUNT)) begin
              ptr_nxt   = '0;
              state_nxt = S_SCROLL;
            end else begin
              cursor_nxt    = cur_nl;
              col_nxt       = '0;
              phase_nxt     = rp_adv;
              row_phase_nxt = rp_adv;
              state_nxt     = S_RESP;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end

      S_READ_WAIT: state_nxt = S_RESP;

      // Move every row up by one and blank the bottom row. The read of a cell
      // runs in the cycle before its write.
      S_SCROLL: begin
        mem_raddr = AW'(ptr_r + PW'(COLUMNS));
        mem_re    = (ptr_r < PW'(COPY_COUNT));
        mem_we    = (ptr_r != '0);
        mem_waddr = wr_ptr[AW-1:0];
        mem_wdata = (ptr_r <= PW'(COPY_COUNT)) ? rd_data_r
                                               : {cfg_i.text_attribute, CHAR_NUL};
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == PW'(CELL_COUNT)) begin
          cursor_nxt    = AW'(COPY_COUNT);
          col_nxt       = '0;
          phase_nxt     = TW'(LAST_PHASE);
          row_phase_nxt = TW'(LAST_PHASE);
          state_nxt     = S_RESP;
        end
      end

      // First or only result of the item.
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_cursor_nxt = cur_ext[IDX_W-1:0];
          out_cell_nxt   = (cmd_r.kind == KIND_READ && rd_ok_r) ? rd_data_r : '0;
          out_sval_nxt   = mirror_it;
          out_byte_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
          if (mirror_it) begin
            out_byte_nxt = cmd_r.char_code;
            if (cmd_r.kind == KIND_NEWLINE) begin
              out_byte_nxt = CHAR_CR;
              out_last_nxt = 1'b0;
              state_nxt    = S_RESP2;
            end
          end
        end
      end

      // Line feed after the carriage return of a mirrored newline.
      S_RESP2: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = CHAR_LF;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_item_r  <= 1'b0;
      ptr_r       <= '0;
      cursor_r    <= '0;
      col_r       <= '0;
      phase_r     <= '0;
      row_phase_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_item_r  <= clr_item_nxt;
      ptr_r       <= ptr_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      phase_r     <= phase_nxt;
      row_phase_r <= row_phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    rd_ok_r      <= rd_ok_nxt;
    out_byte_r   <= out_byte_nxt;
    out_sval_r   <= out_sval_nxt;
    out_cursor_r <= out_cursor_nxt;
    out_cell_r   <= out_cell_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Screen memory ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= screen_mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/text_console_character_writer.sv =====
// Top level of the text console character writer: configuration registers,
// front end, command queue and back end. Depends on tccw_pkg, tccw_if and the macros header.
//
//   Channel   Dir  Handshake            Contents
//   in_chan   in   valid/ready          operation, char_code, cell_index
//   out_chan  out  valid/ready          serial_byte, serial_valid, cursor_position,
//                                       cell_value, last
//   cfg_*     in   cfg_we, no wait      cfg_index, cfg_wdata
//
// In the back end a mirrored newline gives a line feed result after its carriage return,
// a tab writes spaces up to the next stop, and the screen scrolls through the
// single-write, single-read screen memory when the cursor runs past the last cell. A
// clear item zeroes every cell again.
// After reset a clearing pass zeroes the memory; no item is taken until it ends. A
// two-entry command queue lets input items be taken while the back end works or a
// result waits for out_chan.ready.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_character_writer_macros.svh"

module text_console_character_writer #(
  parameter int COLUMNS  = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS     = tccw_pkg::DEF_ROWS,
  parameter int TAB_STOP = tccw_pkg::DEF_TAB_STOP
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tccw_in_if.sink                            in_chan,
  tccw_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tccw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;

  cfg_t    cfg_r, cfg_nxt;
  status_t status;
  cmd_t    front_cmd, head_cmd;
  logic    push, pop, fifo_full, fifo_empty;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ENABLED:        cfg_nxt.enabled        = cfg_wdata[0];
        REG_SERIAL_MIRROR:  cfg_nxt.serial_mirror  = cfg_wdata[0];
        REG_TEXT_ATTRIBUTE: cfg_nxt.text_attribute = cfg_wdata[ATTR_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled        <= 1'b1;
      cfg_r.serial_mirror  <= 1'b0;
      cfg_r.text_attribute <= ATTR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tccw_front u_front (
    .in_chan     (in_chan),
    .cfg_i       (cfg_r),
    .status_i    (status),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  tccw_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .head_o  (head_cmd)
  );

  tccw_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg_r),
    .fifo_empty_i (fifo_empty),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .status_o     (status),
    .out_chan     (out_chan)
  );

  // No item is taken while the power-up clearing pass runs.
  `TCCW_ASSERT_IMPL(a_no_accept_in_init, status.init_busy, !in_chan.ready)
  // The cursor reported with a result always lies on the screen.
  `TCCW_ASSERT_IMPL(a_cursor_on_screen, out_chan.valid, 32'(out_chan.cursor_position) < CELL_COUNT)
  // Only the carriage return of a mirrored newline is a non-final result.
  `TCCW_ASSERT_IMPL(a_cr_before_lf, out_chan.valid && !out_chan.last, out_chan.serial_valid && out_chan.serial_byte == CHAR_CR)
  // A carriage return that is taken is followed by the line feed.
  `TCCW_ASSERT_NEXT(a_lf_follows, out_chan.valid && out_chan.ready && !out_chan.last, out_chan.valid && out_chan.last && out_chan.serial_byte == CHAR_LF)

endmodule

`default_nettype wire

// ===== tb/sv/text_console_character_writer_tb.sv =====
// Self-checking testbench for the text console character writer.
// Needs tccw_pkg, tccw_if and the top level; a shadow screen predicts every result item but for typed rows.
`timescale 1ns / 1ps

module text_console_character_writer_tb;
  import tccw_pkg::*;

  localparam int COLUMNS      = DEF_COLUMNS;
  localparam int ROWS         = DEF_ROWS;
  localparam int TAB_STOP     = DEF_TAB_STOP;
  localparam int CELL_COUNT   = COLUMNS * ROWS;
  localparam int IDX_MAX      = (1 << IDX_W) - 1;
  localparam int SEND_GAP_MAX = 40;
  // A clear or a scroll walks the whole screen once.
  localparam int QUIET_CYCLES = CELL_COUNT + 64;
  // Every item scrolling, every result stalled and every gap at its longest, four times over.
  localparam int LIMIT_CYCLES =
    4 * (1600 * (SEND_GAP_MAX + CELL_COUNT + TAB_STOP + 140) + 24 * QUIET_CYCLES + CELL_COUNT);

  // The one operation code that the block does not define.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] serial_byte;
    logic              serial_valid;
    logic [IDX_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_value;
    logic              last;
  } console_result_t;

  // A row is either an item or a register write (code is then the register index).
  typedef struct packed {
    row_kind_t         kind;
    logic [OP_W-1:0]   code;
    logic [CHAR_W-1:0] data;
    logic [IDX_W-1:0]  index;
    logic              typed;
    logic [IDX_W-1:0]  want_cursor;
    logic [CELL_W-1:0] want_cell;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 30;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Out of reset every cell and the cursor read as zero; past the screen reads zero.
    '{ROW_ITEM, OP_READ,   8'h00,    11'd0,    1'b1, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_READ,   8'hFF,    11'd1999, 1'b1, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_READ,   8'h00,    11'd2000, 1'b1, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_READ,   8'h00,    11'h7FF,  1'b1, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_PUT,    CHAR_NUL, 11'h7FF,  1'b1, 11'd0, 16'h0000},
    // Plain characters, reads, a tab, a newline, a carriage return, an unused code and a clear.
    '{ROW_ITEM, OP_PUT,    8'h41,    11'd0,    1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_PUT,    8'hFF,    11'd0,    1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_READ,   8'h00,    11'd0,    1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_READ,   8'h00,    11'd1,    1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_PUT,    CHAR_TAB, 11'd0,    1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_PUT,    CHAR_LF,  11'd0,    1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_PUT,    CHAR_CR,  11'd0,    1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_UNUSED, 8'hFF,    11'h7FF,  1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_READ,   8'h00,    11'd80,   1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_CLEAR,  8'hFF,    11'h7FF,  1'b1, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_READ,   8'h00,    11'd80,   1'b1, 11'd0, 16'h0000},
    // Serial mirroring with the brightest attribute: a newline goes out as two items.
    '{ROW_REG,  REG_SERIAL_MIRROR,  8'h01, 11'd0, 1'b0, 11'd0, 16'h0000},
    '{ROW_REG,  REG_TEXT_ATTRIBUTE, 8'hFF, 11'd0, 1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_PUT,    CHAR_LF,  11'd0,    1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_PUT,    8'h7E,    11'd0,    1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_PUT,    CHAR_NUL, 11'd0,    1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_PUT,    CHAR_TAB, 11'd0,    1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_READ,   8'h00,    11'd80,   1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_READ,   8'h00,    11'd87,   1'b0, 11'd0, 16'h0000},
    // While disabled nothing answers and nothing changes.
    '{ROW_REG,  REG_ENABLED,        8'h00, 11'd0, 1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_PUT,    8'h41,    11'd80,   1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_CLEAR,  8'h00,    11'd0,    1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_READ,   8'h00,    11'd80,   1'b0, 11'd0, 16'h0000},
    '{ROW_REG,  REG_ENABLED,        8'h01, 11'd0, 1'b0, 11'd0, 16'h0000},
    '{ROW_ITEM, OP_READ,   8'h00,    11'd80,   1'b0, 11'd0, 16'h0000}
  };

  // Random phases; an attribute of -1 is drawn at random.
  localparam int PHASES = 8;
  int phase_items   [PHASES] = '{200, 200, 200, 40, 230, 230, 230, 235};
  bit phase_enabled [PHASES] = '{1, 1, 1, 0, 1, 1, 1, 1};
  bit phase_mirror  [PHASES] = '{0, 1, 1, 1, 0, 1, 0, 1};
  int phase_attr    [PHASES] = '{7, 255, 0, -1, -1, -1, 128, -1};
  int phase_lf_pct  [PHASES] = '{15, 15, 2, 15, 15, 2, 12, 2};

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tccw_in_if  in_if ();
  tccw_out_if out_if ();

  text_console_character_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the screen, the cursor and the registers.
  logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
  int                shadow_cursor;
  logic              shadow_enabled;
  logic              shadow_mirror;
  logic [ATTR_W-1:0] shadow_attr;

  console_result_t item_results [$];
  console_result_t pending_results [$];

  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int unsigned cycle_count;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Result side: ready drops at random in the stalling phases.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic void add_result(input logic [CHAR_W-1:0] sbyte, input logic svalid,
                                     input logic [CELL_W-1:0] cell_val, input logic is_last);
    item_results.push_back(console_result_t'{sbyte, svalid, IDX_W'(shadow_cursor), cell_val,
                                             is_last});
  endfunction

  function automatic void write_cell(input logic [CHAR_W-1:0] ch);
    if (shadow_cursor < CELL_COUNT) begin
      shadow_cells[shadow_cursor] = {shadow_attr, ch};
      shadow_cursor++;
    end
  endfunction

  // Applies one item to the shadow screen and leaves its result items in item_results.
  task automatic shadow_apply_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                   input logic [IDX_W-1:0] idx);
    item_results.delete();
    if (shadow_enabled) begin
      if (op == OP_CLEAR) begin
        foreach (shadow_cells[k]) shadow_cells[k] = '0;
        shadow_cursor = 0;
        add_result(CHAR_NUL, 1'b0, '0, 1'b1);
      end else if (op == OP_READ) begin
        add_result(CHAR_NUL, 1'b0, (idx < CELL_COUNT) ? shadow_cells[idx] : '0, 1'b1);
      end else if (op != OP_PUT || ch == CHAR_NUL) begin
        add_result(CHAR_NUL, 1'b0, '0, 1'b1);
      end else begin
        if (ch == CHAR_LF) begin
          shadow_cursor = (shadow_cursor / COLUMNS + 1) * COLUMNS;
        end else if (ch == CHAR_TAB) begin
          repeat (TAB_STOP - shadow_cursor % TAB_STOP) write_cell(CHAR_SPACE);
        end else begin
          write_cell(ch);
        end
        // Running off the screen drops the top row and blanks the bottom one.
        if (shadow_cursor >= CELL_COUNT) begin
          for (int k = 0; k < CELL_COUNT - COLUMNS; k++) shadow_cells[k] = shadow_cells[k + COLUMNS];
          for (int k = CELL_COUNT - COLUMNS; k < CELL_COUNT; k++)
            shadow_cells[k] = {shadow_attr, CHAR_NUL};
          shadow_cursor = (ROWS - 1) * COLUMNS;
        end
        if (!shadow_mirror) begin
          add_result(CHAR_NUL, 1'b0, '0, 1'b1);
        end else if (ch == CHAR_LF) begin
          add_result(CHAR_CR, 1'b1, '0, 1'b0);
          add_result(CHAR_LF, 1'b1, '0, 1'b1);
        end else begin
          add_result(ch, 1'b1, '0, 1'b1);
        end
      end
    end
  endtask

  // Sends one item, optionally after every pending result has come back.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx, input bit drain_first,
                           input logic typed, input logic [IDX_W-1:0] want_cursor,
                           input logic [CELL_W-1:0] want_cell);
    int gap;
    gap = 0;
    while (gap < SEND_GAP_MAX && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (drain_first || gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain_first) begin
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.char_code  <= ch;
    in_if.cell_index <= idx;
    do @(posedge clk); while (!in_if.ready);
    shadow_apply_item(op, ch, idx);
    if (typed)
      pending_results.push_back(console_result_t'{CHAR_NUL, 1'b0, want_cursor, want_cell, 1'b1});
    else
      foreach (item_results[k]) pending_results.push_back(item_results[k]);
  endtask

  // Stops sending, waits for every result and lets a clear or scroll run out.
  task automatic settle_console();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] which,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (which)
      REG_ENABLED:        shadow_enabled = value[0];
      REG_SERIAL_MIRROR:  shadow_mirror  = value[0];
      REG_TEXT_ATTRIBUTE: shadow_attr    = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Mostly text with newlines and tabs, reads near the cursor, few clears.
  task automatic pick_random_item(input int lf_pct, output logic [OP_W-1:0] op,
                                  output logic [CHAR_W-1:0] ch, output logic [IDX_W-1:0] idx);
    int pick;
    int near;
    pick = $urandom_range(0, 999);
    ch   = CHAR_W'($urandom_range(0, 255));
    idx  = IDX_W'($urandom_range(0, IDX_MAX));
    if (pick < 600) begin
      op   = OP_PUT;
      pick = $urandom_range(0, 99);
      if (pick < lf_pct)           ch = CHAR_LF;
      else if (pick < lf_pct + 7)  ch = CHAR_TAB;
      else if (pick < lf_pct + 10) ch = CHAR_NUL;
      else if (pick < lf_pct + 13) ch = CHAR_CR;
      else if (pick < lf_pct + 17) ch = CHAR_SPACE;
      else if (pick < 80)          ch = CHAR_W'($urandom_range(33, 126));
      else if (ch == CHAR_NUL)     ch = CHAR_W'($urandom_range(128, 255));
    end else if (pick < 930) begin
      op   = OP_READ;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        near = shadow_cursor - int'($urandom_range(0, 100));
        idx  = IDX_W'((near < 0) ? 0 : near);
      end else if (pick < 90) begin
        idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
      end else begin
        idx = IDX_W'($urandom_range(CELL_COUNT, IDX_MAX));
      end
    end else if (pick < 931) begin
      op = OP_CLEAR;
    end else begin
      op = OP_UNUSED;
    end
  endtask

  // Every accepted result item is checked against the oldest expectation.
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    console_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: cursor 0x%0h", out_if.cursor_position);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("serial_byte", want.serial_byte, out_if.serial_byte);
        check_field("serial_valid", want.serial_valid, out_if.serial_valid);
        check_field("cursor_position", want.cursor_position, out_if.cursor_position);
        check_field("cell_value", want.cell_value, out_if.cell_value);
        check_field("last", want.last, out_if.last);
      end
    end
  end

  // Stimulus: directed rows, then random phases over several register settings.
  initial begin
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    logic [ATTR_W-1:0] attr;

    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (shadow_cells[k]) shadow_cells[k] = '0;
    shadow_cursor  = 0;
    shadow_enabled = 1'b1;
    shadow_mirror  = 1'b0;
    shadow_attr    = ATTR_RESET;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_ENABLED;
    cfg_wdata        <= '0;
    in_if.valid      <= 1'b0;
    in_if.operation  <= OP_PUT;
    in_if.char_code  <= CHAR_NUL;
    in_if.cell_index <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_REG) begin
        settle_console();
        write_register(directed_rows[r].code, directed_rows[r].data);
      end else begin
        send_item(directed_rows[r].code, directed_rows[r].data, directed_rows[r].index, 1'b0,
                  directed_rows[r].typed, directed_rows[r].want_cursor,
                  directed_rows[r].want_cell);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle_console();
      attr = (phase_attr[p] < 0) ? ATTR_W'($urandom_range(0, 255)) : ATTR_W'(phase_attr[p]);
      write_register(REG_ENABLED, CFG_DATA_W'(phase_enabled[p]));
      write_register(REG_SERIAL_MIRROR, CFG_DATA_W'(phase_mirror[p]));
      write_register(REG_TEXT_ATTRIBUTE, attr);
      case (idle_mode_t'(p % 4))
        IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        IDLE_SENDER:   begin send_idle_pct = 61; recv_stall_pct = 0;  end
        IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default:       begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int n = 0; n < phase_items[p]; n++) begin
        pick_random_item(phase_lf_pct[p], op, ch, idx);
        send_item(op, ch, idx, (n == 100) || ($urandom_range(0, 99) == 0), 1'b0, '0, '0);
      end
    end

    settle_console();
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
